// File: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sequence check failed");

// antecedent holds, consequent holds in the same cycle
`define CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

// File: design/sccl_pkg.sv
// shared types and constants for the condensed longest path block
package sccl_pkg;

    localparam int PAGE_W = 11;
    localparam int CNT_W  = 11;

    // datapath operation for the current cycle
    typedef enum logic [5:0] {
        C_LOAD, C_CLR, C_CNT_RD, C_CNT_ADR, C_CNT_WR, C_PRE_RD, C_PRE_WR,
        C_FIL_RD, C_FIL_ADR, C_FIL_WR, C_ROOT, C_ROOT_CHK, C_VIS_A, C_VIS_B,
        C_LOOP, C_LOOP_A, C_LOOP_B, C_EDGE_A, C_EDGE_B, C_POP, C_STK_A, C_STK_B,
        C_PAR, C_PAR_A, C_PAR_B, C_INIT_RD, C_INIT_WR, C_CMP_RD, C_CMP_HDR,
        C_MEM_RD, C_MEM_ADJ, C_MEM_RNG, C_ADJ_RD, C_ADJ_CMP, C_ADJ_D, C_ADJ_WR,
        C_CMP_END, C_OUT
    } t_cmd;

    // datapath flags back to the controller; cond depends on the command
    typedef struct packed {
        logic last_acc;
        logic empty;
        logic cond;
    } t_status;

endpackage

// File: design/scc_condensed_longest_path_top.sv
// top level of the condensed-graph longest walk block
// Usage:
//   Configuration: write node_count on i_cfg_valid/i_node_count while idle;
//   o_cfg_ready is always high. Nodes are numbered 1..node_count.
//   Input: one edge per beat (i_source_page, i_target_page, i_last_edge),
//   taken when i_valid is high and o_stall is low. Edges load at one per
//   cycle. Bad, out-of-range or overflow edges are dropped and flagged.
//   The beat with i_last_edge starts the computation; o_stall stays high
//   until the result is written to the output register.
//   Compute: a clearing pass over the offset table and node flags, an
//   adjacency build over the stored edges, then the component search, then
//   the path pass over the components. Each step is one command from the
//   sequencer to the work memories; the offset table has two read ports.
//   Output: one beat (o_max_visitable, o_edge_dropped) per graph on o_valid,
//   held while i_stall is high; a new graph may load while it waits.
//   Reset (synchronous, i_rst_n low) clears node_count, the edge count and
//   the drop flag and empties the output register.
module scc_condensed_longest_path_top import sccl_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_node_count,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PAGE_W-1:0] i_source_page,
    input  logic [PAGE_W-1:0] i_target_page,
    input  logic              i_last_edge,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CNT_W-1:0]  o_max_visitable,
    output logic              o_edge_dropped
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    sccl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // memories and arithmetic
    sccl_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_node_count    (i_node_count),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_source_page   (i_source_page),
        .i_target_page   (i_target_page),
        .i_last_edge     (i_last_edge),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_max_visitable (o_max_visitable),
        .o_edge_dropped  (o_edge_dropped)
    );

endmodule

// File: design/sccl_ctrl.sv
// sequencer for loading, component search and path pass
module sccl_ctrl import sccl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_LOAD, S_CLR, S_CNT_RD, S_CNT_ADR, S_CNT_WR, S_PRE_RD, S_PRE_WR,
        S_FIL_RD, S_FIL_ADR, S_FIL_WR, S_ROOT, S_ROOT_CHK, S_VIS_A, S_VIS_B,
        S_LOOP, S_LOOP_A, S_LOOP_B, S_EDGE_A, S_EDGE_B, S_POP, S_STK_A, S_STK_B,
        S_PAR, S_PAR_A, S_PAR_B, S_INIT_RD, S_INIT_WR, S_CMP_RD, S_CMP_HDR,
        S_MEM_RD, S_MEM_ADJ, S_MEM_RNG, S_ADJ_RD, S_ADJ_CMP, S_ADJ_D, S_ADJ_WR,
        S_CMP_END, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   c;

    // each state issues the command of the same position
    assign o_cmd = t_cmd'(r_state);
    assign c     = i_status.cond;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_status.last_acc) n_state = i_status.empty ? S_OUT : S_CLR;
            end
            S_CLR:      if (c) n_state = S_CNT_RD;
            S_CNT_RD:   n_state = c ? S_PRE_RD : S_CNT_ADR;
            S_CNT_ADR:  n_state = c ? S_CNT_WR : S_CNT_RD;
            S_CNT_WR:   n_state = S_CNT_RD;
            S_PRE_RD:   n_state = c ? S_FIL_RD : S_PRE_WR;
            S_PRE_WR:   n_state = S_PRE_RD;
            S_FIL_RD:   n_state = c ? S_ROOT : S_FIL_ADR;
            S_FIL_ADR:  n_state = c ? S_FIL_WR : S_FIL_RD;
            S_FIL_WR:   n_state = S_FIL_RD;
            S_ROOT:     n_state = c ? S_INIT_RD : S_ROOT_CHK;
            S_ROOT_CHK: n_state = c ? S_ROOT : S_VIS_A;
            S_VIS_A:    n_state = S_VIS_B;
            S_VIS_B:    n_state = S_LOOP;
            S_LOOP:     n_state = c ? S_ROOT : S_LOOP_A;
            S_LOOP_A:   n_state = S_LOOP_B;
            S_LOOP_B:   n_state = c ? S_EDGE_A : S_POP;
            S_EDGE_A:   n_state = S_EDGE_B;
            S_EDGE_B:   n_state = c ? S_LOOP : S_VIS_A;
            S_POP:      n_state = c ? S_STK_A : S_PAR;
            S_STK_A:    n_state = S_STK_B;
            S_STK_B:    n_state = c ? S_PAR : S_STK_A;
            S_PAR:      n_state = c ? S_LOOP : S_PAR_A;
            S_PAR_A:    n_state = S_PAR_B;
            S_PAR_B:    n_state = S_LOOP;
            S_INIT_RD:  n_state = c ? S_CMP_RD : S_INIT_WR;
            S_INIT_WR:  n_state = S_INIT_RD;
            S_CMP_RD:   n_state = c ? S_OUT : S_CMP_HDR;
            S_CMP_HDR:  n_state = S_MEM_RD;
            S_MEM_RD:   n_state = c ? S_CMP_END : S_MEM_ADJ;
            S_MEM_ADJ:  n_state = S_MEM_RNG;
            S_MEM_RNG:  n_state = S_ADJ_RD;
            S_ADJ_RD:   n_state = c ? S_MEM_RD : S_ADJ_CMP;
            S_ADJ_CMP:  n_state = S_ADJ_D;
            S_ADJ_D:    n_state = c ? S_ADJ_WR : S_ADJ_RD;
            S_ADJ_WR:   n_state = S_ADJ_RD;
            S_CMP_END:  n_state = S_CMP_RD;
            S_OUT:      if (c) n_state = S_LOAD;
            default:    n_state = S_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/sccl_dp.sv
// datapath: edge store, adjacency, component search and path memories
module sccl_dp import sccl_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_node_count,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PAGE_W-1:0] i_source_page,
    input  logic [PAGE_W-1:0] i_target_page,
    input  logic              i_last_edge,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CNT_W-1:0]  o_max_visitable,
    output logic              o_edge_dropped
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);

    // memories
    logic [NW-1:0]  r_src_mem [MAX_EDGES];
    logic [NW-1:0]  r_tgt_mem [MAX_EDGES];
    logic [NW-1:0]  r_adj_mem [MAX_EDGES];
    logic [ECW-1:0] r_cnt_mem [MAX_NODES+1];
    logic [ECW-1:0] r_fill_mem [MAX_NODES];
    logic           r_vis_mem [MAX_NODES];
    logic           r_onst_mem [MAX_NODES];
    logic [NW-1:0]  r_disc_mem [MAX_NODES];
    logic [NW-1:0]  r_low_mem [MAX_NODES];
    logic [NW-1:0]  r_comp_mem [MAX_NODES];
    logic [NW-1:0]  r_nstk_mem [MAX_NODES];
    logic [NW-1:0]  r_fnode_mem [MAX_NODES];
    logic [ECW-1:0] r_fcur_mem [MAX_NODES];
    logic [AW-1:0]  r_csize_mem [MAX_NODES];
    logic [AW-1:0]  r_cfirst_mem [MAX_NODES];
    logic [AW-1:0]  r_best_mem [MAX_NODES];
    logic [NW-1:0]  r_member_mem [MAX_NODES];

    // registered read data
    logic [NW-1:0]  r_src_q, r_tgt_q, r_adj_q, r_disc_q, r_low_q, r_comp_q;
    logic [NW-1:0]  r_nstk_q, r_fnode_q, r_member_q;
    logic [ECW-1:0] r_cnt_qa, r_cnt_qb, r_fill_q, r_fcur_q;
    logic           r_vis_q, r_onst_q;
    logic [AW-1:0]  r_csize_q, r_cfirst_q, r_best_q;

    // memory control
    logic           edge_we;
    logic [EW-1:0]  adj_ra, adj_wa;
    logic           adj_we;
    logic [AW-1:0]  cnt_ra_a, cnt_ra_b, cnt_wa;
    logic           cnt_we;
    logic [ECW-1:0] cnt_wd, fill_wd, fcur_wd;
    logic [NW-1:0]  fill_ra, fill_wa;
    logic           fill_we;
    logic [NW-1:0]  vis_ra, vis_wa, onst_wa, disc_ra, low_ra, low_wa, low_wd;
    logic           vis_we, vis_wd, onst_we, onst_wd, disc_we, low_we;
    logic [NW-1:0]  comp_ra, comp_wa, comp_wd, nstk_ra, nstk_wa, nstk_wd;
    logic           comp_we, nstk_we, fnode_we, fcur_we;
    logic [NW-1:0]  fnode_ra, fnode_wa, fnode_wd;
    logic [NW-1:0]  csize_ra, csize_wa, cfirst_ra, cfirst_wa, best_ra, best_wa;
    logic           csize_we, cfirst_we, best_we, member_we;
    logic [AW-1:0]  csize_wd, cfirst_wd, best_wd;
    logic [NW-1:0]  member_ra, member_wa, member_wd;

    // control and working registers
    logic [CNT_W-1:0] r_node_count;
    logic [ECW-1:0]   r_loaded, r_e, r_sum, r_cur, r_j, r_jend;
    logic             r_drop;
    logic [AW-1:0]    r_i, r_cntr, r_sp, r_fp, r_comps, r_members, r_size;
    logic [AW-1:0]    r_c, r_mptr, r_mend, r_bc, r_best;
    logic [NW-1:0]    r_u, r_v, r_p, r_d, r_low_u, r_disc_u;
    logic             r_o_valid, r_o_drop;
    logic [CNT_W-1:0] r_o_max;

    logic [AW-1:0] act_n, cand;
    logic          accept, bad_edge, edge_ok, has_edge, cond;
    logic [NW-1:0] fp_m1, sp_m1;

    // active node count and load checks
    always_comb begin
        act_n    = (32'(r_node_count) > 32'(MAX_NODES)) ? AW'(MAX_NODES) : AW'(r_node_count);
        accept   = i_valid && (i_cmd == C_LOAD);
        bad_edge = (i_source_page == '0) || (i_target_page == '0)
                || (32'(i_source_page) > 32'(act_n)) || (32'(i_target_page) > 32'(act_n))
                || (i_source_page == i_target_page)
                || (32'(r_loaded) >= 32'(MAX_EDGES));
        edge_ok  = (AW'(r_src_q) < act_n) && (AW'(r_tgt_q) < act_n);
        has_edge = r_cur < r_cnt_qa;
        fp_m1    = NW'(r_fp - AW'(1));
        sp_m1    = NW'(r_sp - AW'(1));
        cand     = r_bc + r_csize_q;
        edge_we  = accept && !bad_edge;
    end

    assign o_stall         = (i_cmd != C_LOAD);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_o_valid;
    assign o_max_visitable = r_o_max;
    assign o_edge_dropped  = r_o_drop;

    // per-command condition reported to the controller
    always_comb begin
        case (i_cmd)
            C_CLR:                cond = (r_i == act_n);
            C_CNT_RD, C_FIL_RD:   cond = (r_e == r_loaded);
            C_CNT_ADR, C_FIL_ADR: cond = edge_ok;
            C_PRE_RD:             cond = (r_i > act_n);
            C_ROOT:               cond = (r_i == act_n);
            C_ROOT_CHK, C_EDGE_B: cond = r_vis_q;
            C_LOOP, C_PAR:        cond = (r_fp == '0);
            C_LOOP_B:             cond = has_edge;
            C_POP:                cond = (r_low_u == r_disc_u);
            C_STK_B:              cond = (r_nstk_q == r_u);
            C_INIT_RD:            cond = (r_c == r_comps);
            C_CMP_RD:             cond = (r_c == '0);
            C_MEM_RD:             cond = (r_mptr == r_mend);
            C_ADJ_RD:             cond = (r_j == r_jend);
            C_ADJ_D:              cond = (AW'(r_comp_q) != r_c);
            C_OUT:                cond = !r_o_valid || !i_stall;
            default:              cond = 1'b0;
        endcase
        o_status.cond     = cond;
        o_status.last_acc = accept && i_last_edge;
        o_status.empty    = (act_n == '0);
    end

    // memory addresses and writes per command
    always_comb begin
        adj_ra = '0; adj_wa = '0; adj_we = 1'b0;
        cnt_ra_a = '0; cnt_ra_b = '0; cnt_wa = '0; cnt_we = 1'b0; cnt_wd = '0;
        fill_ra = '0; fill_wa = '0; fill_we = 1'b0; fill_wd = '0;
        vis_ra = '0; vis_wa = '0; vis_we = 1'b0; vis_wd = 1'b0;
        onst_wa = '0; onst_we = 1'b0; onst_wd = 1'b0;
        disc_ra = '0; disc_we = 1'b0; low_ra = '0; low_wa = '0; low_we = 1'b0; low_wd = '0;
        comp_ra = '0; comp_wa = '0; comp_we = 1'b0; comp_wd = '0;
        nstk_ra = '0; nstk_wa = '0; nstk_we = 1'b0; nstk_wd = '0;
        fnode_ra = '0; fnode_wa = '0; fnode_we = 1'b0; fnode_wd = '0;
        fcur_we = 1'b0; fcur_wd = '0;
        csize_ra = '0; csize_wa = '0; csize_we = 1'b0; csize_wd = '0;
        cfirst_ra = '0; cfirst_wa = '0; cfirst_we = 1'b0; cfirst_wd = '0;
        best_ra = '0; best_wa = '0; best_we = 1'b0; best_wd = '0;
        member_ra = '0; member_wa = '0; member_we = 1'b0; member_wd = '0;
        case (i_cmd)
            C_CLR: begin
                cnt_we = 1'b1; cnt_wa = r_i;
                if (r_i < act_n) begin
                    vis_we = 1'b1; vis_wa = NW'(r_i);
                    onst_we = 1'b1; onst_wa = NW'(r_i);
                end
            end
            C_CNT_ADR: cnt_ra_a = AW'(r_src_q) + AW'(1);
            C_CNT_WR: begin
                cnt_we = 1'b1; cnt_wa = AW'(r_u) + AW'(1); cnt_wd = r_cnt_qa + ECW'(1);
            end
            C_PRE_RD: cnt_ra_a = r_i;
            C_PRE_WR: begin
                cnt_we = 1'b1; cnt_wa = r_i; cnt_wd = r_sum + r_cnt_qa;
                fill_we = 1'b1; fill_wa = NW'(r_i - AW'(1)); fill_wd = r_sum;
            end
            C_FIL_ADR: fill_ra = r_src_q;
            C_FIL_WR: begin
                adj_we = 1'b1; adj_wa = EW'(r_fill_q);
                fill_we = 1'b1; fill_wa = r_u; fill_wd = r_fill_q + ECW'(1);
            end
            C_ROOT: vis_ra = NW'(r_i);
            C_VIS_A: cnt_ra_a = AW'(r_v);
            C_VIS_B: begin
                vis_we = 1'b1; vis_wa = r_v; vis_wd = 1'b1;
                onst_we = 1'b1; onst_wa = r_v; onst_wd = 1'b1;
                disc_we = 1'b1; low_we = 1'b1; low_wa = r_v; low_wd = NW'(r_cntr);
                nstk_we = 1'b1; nstk_wa = NW'(r_sp); nstk_wd = r_v;
                fnode_we = 1'b1; fnode_wa = NW'(r_fp); fnode_wd = r_v;
                fcur_we = 1'b1; fcur_wd = r_cnt_qa;
            end
            C_LOOP: fnode_ra = fp_m1;
            C_LOOP_A: begin
                cnt_ra_a = AW'(r_fnode_q) + AW'(1);
                low_ra = r_fnode_q; disc_ra = r_fnode_q;
            end
            C_LOOP_B: begin
                adj_ra = EW'(r_cur);
                if (has_edge) begin
                    fcur_we = 1'b1; fnode_wa = fp_m1; fcur_wd = r_cur + ECW'(1);
                end
            end
            C_EDGE_A: begin
                vis_ra = r_adj_q; disc_ra = r_adj_q;
            end
            C_EDGE_B: begin
                if (r_vis_q && r_onst_q && (r_disc_q < r_low_u)) begin
                    low_we = 1'b1; low_wa = r_u; low_wd = r_disc_q;
                end
            end
            C_POP: begin
                if (r_low_u == r_disc_u) begin
                    cfirst_we = 1'b1; cfirst_wa = NW'(r_comps); cfirst_wd = r_members;
                end
            end
            C_STK_A: nstk_ra = sp_m1;
            C_STK_B: begin
                onst_we = 1'b1; onst_wa = r_nstk_q;
                comp_we = 1'b1; comp_wa = r_nstk_q; comp_wd = NW'(r_comps);
                member_we = 1'b1; member_wa = NW'(r_members); member_wd = r_nstk_q;
                if (r_nstk_q == r_u) begin
                    csize_we = 1'b1; csize_wa = NW'(r_comps); csize_wd = r_size + AW'(1);
                end
            end
            C_PAR: fnode_ra = fp_m1;
            C_PAR_A: low_ra = r_fnode_q;
            C_PAR_B: begin
                if (r_low_u < r_low_q) begin
                    low_we = 1'b1; low_wa = r_p; low_wd = r_low_u;
                end
            end
            C_INIT_RD: csize_ra = NW'(r_c);
            C_INIT_WR: begin
                best_we = 1'b1; best_wa = NW'(r_c); best_wd = r_csize_q;
            end
            C_CMP_RD: begin
                cfirst_ra = NW'(r_c - AW'(1));
                csize_ra = NW'(r_c - AW'(1));
                best_ra = NW'(r_c - AW'(1));
            end
            C_MEM_RD: member_ra = NW'(r_mptr);
            C_MEM_ADJ: begin
                cnt_ra_a = AW'(r_member_q);
                cnt_ra_b = AW'(r_member_q) + AW'(1);
            end
            C_ADJ_RD: adj_ra = EW'(r_j);
            C_ADJ_CMP: comp_ra = r_adj_q;
            C_ADJ_D: begin
                csize_ra = r_comp_q; best_ra = r_comp_q;
            end
            C_ADJ_WR: begin
                if (cand > r_best_q) begin
                    best_we = 1'b1; best_wa = r_d; best_wd = cand;
                end
            end
            default: begin
            end
        endcase
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_src_mem[EW'(r_loaded)] <= NW'(i_source_page - PAGE_W'(1));
            r_tgt_mem[EW'(r_loaded)] <= NW'(i_target_page - PAGE_W'(1));
        end
        r_src_q <= r_src_mem[EW'(r_e)];
        r_tgt_q <= r_tgt_mem[EW'(r_e)];
    end

    // adjacency targets
    always_ff @(posedge i_clk) begin
        if (adj_we) r_adj_mem[adj_wa] <= r_v;
        r_adj_q <= r_adj_mem[adj_ra];
    end

    // adjacency start offsets, two read ports
    always_ff @(posedge i_clk) begin
        if (cnt_we) r_cnt_mem[cnt_wa] <= cnt_wd;
        r_cnt_qa <= r_cnt_mem[cnt_ra_a];
        r_cnt_qb <= r_cnt_mem[cnt_ra_b];
    end

    // fill cursors
    always_ff @(posedge i_clk) begin
        if (fill_we) r_fill_mem[fill_wa] <= fill_wd;
        r_fill_q <= r_fill_mem[fill_ra];
    end

    // visited and on-stack flags
    always_ff @(posedge i_clk) begin
        if (vis_we) r_vis_mem[vis_wa] <= vis_wd;
        if (onst_we) r_onst_mem[onst_wa] <= onst_wd;
        r_vis_q  <= r_vis_mem[vis_ra];
        r_onst_q <= r_onst_mem[vis_ra];
    end

    // discovery and low-link numbers
    always_ff @(posedge i_clk) begin
        if (disc_we) r_disc_mem[low_wa] <= low_wd;
        if (low_we) r_low_mem[low_wa] <= low_wd;
        r_disc_q <= r_disc_mem[disc_ra];
        r_low_q  <= r_low_mem[low_ra];
    end

    // component of each node
    always_ff @(posedge i_clk) begin
        if (comp_we) r_comp_mem[comp_wa] <= comp_wd;
        r_comp_q <= r_comp_mem[comp_ra];
    end

    // node stack
    always_ff @(posedge i_clk) begin
        if (nstk_we) r_nstk_mem[nstk_wa] <= nstk_wd;
        r_nstk_q <= r_nstk_mem[nstk_ra];
    end

    // walk frames: node and edge cursor
    always_ff @(posedge i_clk) begin
        if (fnode_we) r_fnode_mem[fnode_wa] <= fnode_wd;
        if (fcur_we) r_fcur_mem[fnode_wa] <= fcur_wd;
        r_fnode_q <= r_fnode_mem[fnode_ra];
        r_fcur_q  <= r_fcur_mem[fnode_ra];
    end

    // component size, first member and best path weight
    always_ff @(posedge i_clk) begin
        if (csize_we) r_csize_mem[csize_wa] <= csize_wd;
        if (cfirst_we) r_cfirst_mem[cfirst_wa] <= cfirst_wd;
        if (best_we) r_best_mem[best_wa] <= best_wd;
        r_csize_q  <= r_csize_mem[csize_ra];
        r_cfirst_q <= r_cfirst_mem[cfirst_ra];
        r_best_q   <= r_best_mem[best_ra];
    end

    // member list grouped by component
    always_ff @(posedge i_clk) begin
        if (member_we) r_member_mem[member_wa] <= member_wd;
        r_member_q <= r_member_mem[member_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_loaded     <= '0;
            r_drop       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) r_node_count <= i_node_count;
            // result beat: load a new one or drop the taken one
            if ((i_cmd == C_OUT) && cond) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (i_cmd)
                C_LOAD: begin
                    if (accept) begin
                        if (bad_edge) r_drop <= 1'b1;
                        else r_loaded <= r_loaded + ECW'(1);
                    end
                end
                C_CNT_ADR: if (!edge_ok) r_drop <= 1'b1;
                C_OUT: begin
                    if (cond) begin
                        r_loaded  <= '0;
                        r_drop    <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LOAD: begin
                r_i    <= '0;
                r_best <= '0;
            end
            C_CLR: begin
                r_i <= r_i + AW'(1);
                r_e <= '0;
            end
            C_CNT_RD: begin
                r_i   <= AW'(1);
                r_sum <= '0;
            end
            C_CNT_ADR: begin
                r_e <= r_e + ECW'(1);
                r_u <= r_src_q;
            end
            C_PRE_RD: r_e <= '0;
            C_PRE_WR: begin
                r_sum <= r_sum + r_cnt_qa;
                r_i   <= r_i + AW'(1);
            end
            C_FIL_RD: begin
                r_i       <= '0;
                r_cntr    <= '0;
                r_sp      <= '0;
                r_fp      <= '0;
                r_comps   <= '0;
                r_members <= '0;
            end
            C_FIL_ADR: begin
                r_e <= r_e + ECW'(1);
                r_u <= r_src_q;
                r_v <= r_tgt_q;
            end
            C_ROOT: r_c <= '0;
            C_ROOT_CHK: begin
                if (r_vis_q) r_i <= r_i + AW'(1);
                else r_v <= NW'(r_i);
            end
            C_VIS_B: begin
                r_sp   <= r_sp + AW'(1);
                r_fp   <= r_fp + AW'(1);
                r_cntr <= r_cntr + AW'(1);
            end
            C_LOOP_A: begin
                r_u   <= r_fnode_q;
                r_cur <= r_fcur_q;
            end
            C_LOOP_B: begin
                r_low_u  <= r_low_q;
                r_disc_u <= r_disc_q;
            end
            C_EDGE_A: r_v <= r_adj_q;
            C_POP: begin
                r_fp   <= r_fp - AW'(1);
                r_size <= '0;
            end
            C_STK_B: begin
                r_sp      <= r_sp - AW'(1);
                r_members <= r_members + AW'(1);
                r_size    <= r_size + AW'(1);
                if (r_nstk_q == r_u) r_comps <= r_comps + AW'(1);
            end
            C_PAR_A: r_p <= r_fnode_q;
            C_INIT_RD: r_best <= '0;
            C_INIT_WR: r_c <= r_c + AW'(1);
            C_CMP_RD: if (r_c != '0) r_c <= r_c - AW'(1);
            C_CMP_HDR: begin
                r_mptr <= r_cfirst_q;
                r_mend <= r_cfirst_q + r_csize_q;
                r_bc   <= r_best_q;
            end
            C_MEM_RD: r_mptr <= r_mptr + AW'(1);
            C_MEM_RNG: begin
                r_j    <= r_cnt_qa;
                r_jend <= r_cnt_qb;
            end
            C_ADJ_RD: r_j <= r_j + ECW'(1);
            C_ADJ_D: r_d <= r_comp_q;
            C_CMP_END: if (r_bc > r_best) r_best <= r_bc;
            C_OUT: begin
                if (cond) begin
                    r_o_max  <= CNT_W'(r_best);
                    r_o_drop <= r_drop;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: design/sccl_chk.sv
// port-level checker for the top level, with its bind
`include "assert_macros.svh"

module sccl_chk import sccl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [CNT_W-1:0]  i_node_count,
    input logic              i_valid,
    input logic              o_stall,
    input logic [PAGE_W-1:0] i_source_page,
    input logic [PAGE_W-1:0] i_target_page,
    input logic              i_last_edge,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CNT_W-1:0]  o_max_visitable,
    input logic              o_edge_dropped
);

    // a stalled result beat stays
    `CHK_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    // a stalled result beat keeps its value
    `CHK_NEXT(a_out_stable, o_valid && i_stall, $stable(o_max_visitable))
    // the final edge blocks further input while the graph is processed
    `CHK_NEXT(a_last_blocks, i_valid && !o_stall && i_last_edge, o_stall)
    // a result appears only after a stretch with the input blocked
    `CHK_NOW(a_result_after_compute, $rose(o_valid), $past(o_stall))
    // an ordinary edge never produces a result
    `CHK_NEXT(a_no_early_result, i_valid && !o_stall && !i_last_edge, !$rose(o_valid))

endmodule

bind scc_condensed_longest_path_top sccl_chk u_sccl_chk (.*);

// File: tb/tb.sv
// testbench for the condensed-graph longest walk block
module tb;
    import sccl_pkg::*;

    localparam int MAX_N = 1024;
    localparam int MAX_E = 4096;
    localparam int WATCHDOG = 2000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_node_count;
    logic              i_valid;
    logic              o_stall;
    logic [PAGE_W-1:0] i_source_page;
    logic [PAGE_W-1:0] i_target_page;
    logic              i_last_edge;
    logic              o_valid;
    logic              i_stall;
    logic [CNT_W-1:0]  o_max_visitable;
    logic              o_edge_dropped;

    scc_condensed_longest_path_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_node_count(i_node_count),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_source_page(i_source_page), .i_target_page(i_target_page),
        .i_last_edge(i_last_edge),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_max_visitable(o_max_visitable), .o_edge_dropped(o_edge_dropped)
    );

    typedef struct {
        logic [CNT_W-1:0] walk;
        logic             dropped;
    } walk_t;

    // predictor state
    int unsigned nodes_cfg;
    int unsigned edge_src[MAX_E];
    int unsigned edge_dst[MAX_E];
    int unsigned n_edges;
    bit          drop_seen;

    // work arrays of the walk computation
    int unsigned adj_start[MAX_N+1];
    int unsigned adj_tgt[MAX_E];
    int unsigned fill[MAX_N];
    bit          seen[MAX_N];
    int unsigned disc[MAX_N];
    int unsigned low[MAX_N];
    bit          on_stk[MAX_N];
    int unsigned comp_of[MAX_N];
    int unsigned stk[MAX_N];
    int unsigned fr_node[MAX_N];
    int unsigned fr_cur[MAX_N];
    int unsigned comp_sz[MAX_N];
    int unsigned comp_first[MAX_N];
    int unsigned members_of[MAX_N];
    int unsigned best_cnt[MAX_N];

    walk_t expected_walks[$];
    int    mismatches;
    int    idle_cycles;
    bit    timed_out;

    // tarjan over stored edges, then heaviest path in the condensation
    function automatic int unsigned longest_walk();
        int unsigned n, cnt, sp, fp, comps, mem, best, u, v, w, p, d;
        n = (nodes_cfg > MAX_N) ? MAX_N : nodes_cfg;
        cnt = 0; sp = 0; fp = 0; comps = 0; mem = 0; best = 0;
        if (n == 0) return 0;
        for (int i = 0; i <= MAX_N; i++) adj_start[i] = 0;
        for (int e = 0; e < n_edges; e++) begin
            if (edge_src[e] >= n || edge_dst[e] >= n) begin
                drop_seen = 1;
                continue;
            end
            adj_start[edge_src[e]+1]++;
        end
        for (int i = 0; i < n; i++) begin
            adj_start[i+1] += adj_start[i];
            fill[i] = adj_start[i];
        end
        for (int e = 0; e < n_edges; e++) begin
            if (edge_src[e] >= n || edge_dst[e] >= n) continue;
            adj_tgt[fill[edge_src[e]]] = edge_dst[e];
            fill[edge_src[e]]++;
        end
        for (int i = 0; i < MAX_N; i++) begin
            seen[i] = 0;
            on_stk[i] = 0;
        end
        for (int r = 0; r < n; r++) begin
            if (seen[r]) continue;
            seen[r] = 1;
            disc[r] = cnt; low[r] = cnt; cnt++;
            stk[sp++] = r; on_stk[r] = 1;
            fr_node[fp] = r; fr_cur[fp] = adj_start[r]; fp++;
            while (fp > 0) begin
                u = fr_node[fp-1];
                if (fr_cur[fp-1] < adj_start[u+1]) begin
                    v = adj_tgt[fr_cur[fp-1]];
                    fr_cur[fp-1]++;
                    if (!seen[v]) begin
                        seen[v] = 1;
                        disc[v] = cnt; low[v] = cnt; cnt++;
                        stk[sp++] = v; on_stk[v] = 1;
                        fr_node[fp] = v; fr_cur[fp] = adj_start[v]; fp++;
                    end else if (on_stk[v] && disc[v] < low[u]) begin
                        low[u] = disc[v];
                    end
                end else begin
                    fp--;
                    if (low[u] == disc[u]) begin
                        comp_first[comps] = mem;
                        comp_sz[comps] = 0;
                        do begin
                            sp--;
                            w = stk[sp];
                            on_stk[w] = 0;
                            comp_of[w] = comps;
                            members_of[mem++] = w;
                            comp_sz[comps]++;
                        end while (w != u);
                        comps++;
                    end
                    if (fp > 0) begin
                        p = fr_node[fp-1];
                        if (low[u] < low[p]) low[p] = low[u];
                    end
                end
            end
        end
        // components finish sinks first, so walk them by descending index
        for (int c = 0; c < comps; c++) best_cnt[c] = comp_sz[c];
        for (int c = comps - 1; c >= 0; c--) begin
            for (int k = 0; k < comp_sz[c]; k++) begin
                u = members_of[comp_first[c] + k];
                for (int j = adj_start[u]; j < adj_start[u+1]; j++) begin
                    d = comp_of[adj_tgt[j]];
                    if (d != c && best_cnt[c] + comp_sz[d] > best_cnt[d])
                        best_cnt[d] = best_cnt[c] + comp_sz[d];
                end
            end
            if (best_cnt[c] > best) best = best_cnt[c];
        end
        return best;
    endfunction

    // one accepted edge beat into the predictor
    function automatic void take_edge(int unsigned s, int unsigned t, bit last);
        int unsigned n;
        walk_t r;
        n = (nodes_cfg > MAX_N) ? MAX_N : nodes_cfg;
        if (s == 0 || t == 0 || s > n || t > n || s == t || n_edges >= MAX_E) begin
            drop_seen = 1;
        end else begin
            edge_src[n_edges] = s - 1;
            edge_dst[n_edges] = t - 1;
            n_edges++;
        end
        if (last) begin
            r.walk = longest_walk();
            r.dropped = drop_seen;
            expected_walks.insert(expected_walks.size(), r);
            n_edges = 0;
            drop_seen = 0;
        end
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stalls on its own pattern, with calm stretches
    int stall_mode;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_stall <= 0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        walk_t exp_r;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_walks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: walk %0d dropped %0d",
                                 o_max_visitable, o_edge_dropped);
                end else begin
                    exp_r = expected_walks.pop_front();
                    if (exp_r.walk !== o_max_visitable
                            || exp_r.dropped !== o_edge_dropped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("walk exp %0d got %0d, dropped exp %0d got %0d",
                                     exp_r.walk, o_max_visitable,
                                     exp_r.dropped, o_edge_dropped);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG && !timed_out) begin
                timed_out = 1;
                $display("scc_condensed_longest_path_top: mismatch");
                $finish;
            end
        end
    end

    // drive one edge beat, with bursty sender gaps; returns at the accepting edge
    int burst_left;
    task automatic send_edge(int unsigned s, int unsigned t, bit last);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) == 0) begin
                i_valid <= 0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1;
        i_source_page <= s[PAGE_W-1:0];
        i_target_page <= t[PAGE_W-1:0];
        i_last_edge <= last;
        do @(posedge i_clk); while (o_stall);
        take_edge(s, t, last);
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (expected_walks.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic set_nodes(int unsigned n);
        drain();
        i_cfg_valid <= 1;
        i_node_count <= n[CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        nodes_cfg = n;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // random graph: mostly valid edges, some bad ones, small sizes dominate
    task automatic random_graph(int unsigned n, int unsigned count);
        int unsigned s, t;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                s = $urandom_range(0, 2047);
                t = $urandom_range(0, 2047);
            end else if (n >= 1) begin
                s = $urandom_range(1, n);
                t = $urandom_range(1, n);
            end else begin
                s = 1; t = 2;
            end
            send_edge(s, t, i == count - 1);
        end
    endtask

    // directed table: node count to use, source, target, last, typed result or -1
    typedef struct {
        int unsigned nodes;
        int unsigned s;
        int unsigned t;
        bit          last;
        int          exp_walk;
        int          exp_drop;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{0,    1,    2,    1, 0,  1},  // empty graph
        '{4,    1,    2,    0, -1, -1},
        '{4,    2,    3,    0, -1, -1},
        '{4,    3,    1,    0, -1, -1},
        '{4,    3,    4,    1, 4,  0},  // cycle plus tail
        '{4,    0,    2,    0, -1, -1}, // zero endpoint
        '{4,    2,    2,    0, -1, -1}, // self loop
        '{4,    5,    1,    0, -1, -1}, // above node count
        '{4,    2047, 2047, 0, -1, -1},
        '{4,    1,    2,    1, 2,  1},
        '{1024, 1,    1024, 0, -1, -1},
        '{1024, 1024, 1,    1, 2,  0},
        '{2047, 1024, 1025, 0, -1, -1}, // oversize count acts as maximum
        '{2047, 1,    1024, 1, 2,  1},
        '{3,    1,    3,    1, 2,  0},
        '{3,    2,    1,    1, 2,  0}
    };

    initial begin
        walk_t hold_r;
        int unsigned n;
        mismatches = 0; idle_cycles = 0; timed_out = 0; stall_mode = 0;
        burst_left = 0; nodes_cfg = 0; n_edges = 0; drop_seen = 0;
        i_rst_n = 0; i_cfg_valid = 0; i_node_count = 0; i_valid = 0;
        i_source_page = 0; i_target_page = 0; i_last_edge = 0; i_stall = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed part
        for (int i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].nodes != nodes_cfg) set_nodes(dir_rows[i].nodes);
            send_edge(dir_rows[i].s, dir_rows[i].t, dir_rows[i].last);
            if (dir_rows[i].last && dir_rows[i].exp_walk >= 0) begin
                hold_r = expected_walks[$];
                if (hold_r.walk != dir_rows[i].exp_walk
                        || hold_r.dropped != dir_rows[i].exp_drop) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: typed %0d/%0d, predicted %0d/%0d", i,
                                 dir_rows[i].exp_walk, dir_rows[i].exp_drop,
                                 hold_r.walk, hold_r.dropped);
                end
            end
        end

        // node count lowered after loading
        set_nodes(8);
        send_edge(7, 8, 0);
        send_edge(1, 2, 0);
        set_nodes(5);
        send_edge(2, 3, 1);

        // one larger graph with many repeated edges
        set_nodes(64);
        random_graph(64, 300);

        // random graphs with mostly small sizes
        for (int g = 0; g < 60; g++) begin
            if (g % 10 == 0) begin
                case ($urandom_range(0, 5))
                    0: n = 1;
                    1: n = 1024;
                    2: n = $urandom_range(1025, 2047);
                    default: n = $urandom_range(2, 24);
                endcase
                set_nodes(n);
            end
            n = (nodes_cfg > MAX_N) ? MAX_N : nodes_cfg;
            random_graph(n, (nodes_cfg > 64) ? $urandom_range(1, 30) : $urandom_range(1, 25));
            if (g == 30) drain();  // sender holds off until all results are back
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && expected_walks.size() == 0)
            $display("scc_condensed_longest_path_top: match");
        else
            $display("scc_condensed_longest_path_top: mismatch");
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/sccl_pkg.sv
design/sccl_ctrl.sv
design/sccl_dp.sv
design/scc_condensed_longest_path_top.sv
design/sccl_chk.sv
tb/tb.sv
